>>> sv/fci_pkg.sv
// Shared types, constants and register codes for the fan curve interpolator.
`default_nettype none

package fci_pkg;

    localparam int TEMP_W     = 13;
    localparam int DUTY_W     = 15;
    localparam int PT_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAX_POINTS = 8;
    localparam int PAIRS      = MAX_POINTS / 2;
    localparam int DIV_STEPS  = PT_W;

    typedef logic signed [TEMP_W-1:0]     t_temp;
    typedef logic [DUTY_W-1:0]            t_duty;
    typedef logic [CFG_IDX_W-1:0]         t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]        t_cfg_data;

    // Absolute zero in eighths of a degree, and 100 % in 1/256 % units.
    localparam t_temp ABS_ZERO  = -13'sd2185;
    localparam t_duty FULL_DUTY = 15'd25600;

    // Blend modes; the fourth code behaves as CPU only.
    localparam logic [1:0] MODE_CPU = 2'd0;
    localparam logic [1:0] MODE_GPU = 2'd1;
    localparam logic [1:0] MODE_MAX = 2'd2;

    // Configuration register indexes.
    localparam t_cfg_idx REG_BLEND_MODE   = 3'd0;
    localparam t_cfg_idx REG_FLOOR_DUTY   = 3'd1;
    localparam t_cfg_idx REG_POINT_COUNT  = 3'd2;
    localparam t_cfg_idx REG_CURVE_PAIR_0 = 3'd3;
    localparam t_cfg_idx REG_CURVE_PAIR_1 = 3'd4;
    localparam t_cfg_idx REG_CURVE_PAIR_2 = 3'd5;
    localparam t_cfg_idx REG_CURVE_PAIR_3 = 3'd6;

endpackage

`default_nettype wire

>>> sv/fci_cfg_if.sv
// Configuration write channel of the fan curve interpolator.
`default_nettype none

interface fci_cfg_if import fci_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/fci_in_if.sv
// Input channel carrying the CPU and GPU temperature readings.
`default_nettype none

interface fci_in_if import fci_pkg::*; ();
    logic  valid;
    logic  ready;
    t_temp cpu_temp;
    logic  cpu_valid;
    t_temp gpu_temp;
    logic  gpu_valid;

    modport source (output valid, output cpu_temp, output cpu_valid,
                    output gpu_temp, output gpu_valid, input ready);
    modport sink   (input valid, input cpu_temp, input cpu_valid,
                    input gpu_temp, input gpu_valid, output ready);
endinterface

`default_nettype wire

>>> sv/fci_out_if.sv
// Output channel carrying the fan duty and the blended temperature.
`default_nettype none

interface fci_out_if import fci_pkg::*; ();
    logic  valid;
    logic  ready;
    t_duty fan_duty;
    t_temp blended_temp;

    modport source (output valid, output fan_duty, output blended_temp, input ready);
    modport sink   (input valid, input fan_duty, input blended_temp, output ready);
endinterface

`default_nettype wire

>>> sv/fan_curve_interpolator.sv
// Fan curve interpolator: temperature blending, curve point scan and serial divider.
// A result enters the output register once that register is free. The curve
// registers are scanned one point per cycle (the first point, then the last,
// then upwards from the second), and an interpolated segment then passes the
// 16x16 multiply and the restoring divider, which retires one quotient bit per
// cycle. Requests that land on a curve end, a flat or reversed segment or an
// empty curve skip the divider.
// The output register lets the next request be accepted while a result waits.
// Configuration writes are always accepted and must only be made while idle.
`default_nettype none

module fan_curve_interpolator import fci_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fci_cfg_if.sink    i_cfg,
    fci_in_if.sink     i_in,
    fci_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int NUM_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    // Configuration registers
    logic [1:0]            r_blend_mode;
    t_duty                 r_floor_duty;
    logic [NUM_W-1:0]      r_point_count;
    t_cfg_data             r_curve [PAIRS];

    // Sequencer and datapath registers
    logic [2:0]            r_state, n_state;
    t_temp                 r_temp, n_temp;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic signed [PT_W-1:0] r_prev_t, n_prev_t;
    logic [PT_W-1:0]       r_prev_d, n_prev_d;
    logic                  r_direct, n_direct;
    logic [PT_W-1:0]       r_raw, n_raw;
    logic [PT_W-1:0]       r_lo, n_lo;
    logic [PT_W-1:0]       r_span, n_span;
    logic [PT_W-1:0]       r_dist, n_dist;
    logic [PT_W-1:0]       r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [PT_W-1:0]       r_rem, n_rem;
    logic [PT_W-1:0]       r_quo, n_quo;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    t_duty                 r_out_duty, n_out_duty;
    t_temp                 r_out_temp, n_out_temp;

    // Combinational helpers
    logic [31:0]           pt_half;
    logic signed [PT_W-1:0] pt_t;
    logic [PT_W-1:0]       pt_d;
    logic signed [PT_W-1:0] t_ext;
    logic [NUM_W-1:0]      n_pts;
    logic [IDX_W-1:0]      last_idx;
    logic signed [PT_W:0]  span_w;
    logic signed [PT_W:0]  dist_w;
    logic signed [PT_W:0]  dd_w;
    logic signed [PT_W:0]  dd_neg;
    logic [2*PT_W-1:0]     prod;
    logic [PT_W:0]         trial;
    logic [PT_W:0]         trial_diff;
    logic                  trial_ge;
    logic [PT_W:0]         interp;
    logic [PT_W:0]         raw_w;
    t_duty                 floor_sat;
    t_duty                 capped;
    t_duty                 duty;
    t_temp                 cpu_t;
    t_temp                 gpu_t;
    t_temp                 blend_t;
    logic                  in_acc;
    logic                  out_load;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode  <= MODE_CPU;
            r_floor_duty  <= '0;
            r_point_count <= '0;
            for (int k = 0; k < PAIRS; k++) begin
                r_curve[k] <= '0;
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_BLEND_MODE:   r_blend_mode  <= i_cfg.data[1:0];
                REG_FLOOR_DUTY:   r_floor_duty  <= i_cfg.data[DUTY_W-1:0];
                REG_POINT_COUNT:  r_point_count <= i_cfg.data[NUM_W-1:0];
                REG_CURVE_PAIR_0: r_curve[0]    <= i_cfg.data;
                REG_CURVE_PAIR_1: r_curve[1]    <= i_cfg.data;
                REG_CURVE_PAIR_2: r_curve[2]    <= i_cfg.data;
                REG_CURVE_PAIR_3: r_curve[3]    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Blending of the two readings at acceptance
    // ---------------------------------------------------------------
    assign cpu_t = i_in.cpu_valid ? i_in.cpu_temp : ABS_ZERO;
    assign gpu_t = i_in.gpu_valid ? i_in.gpu_temp : ABS_ZERO;

    always_comb begin
        unique case (r_blend_mode)
            MODE_GPU: blend_t = gpu_t;
            MODE_MAX: blend_t = (cpu_t > gpu_t) ? cpu_t : gpu_t;
            default:  blend_t = cpu_t;
        endcase
    end

    // ---------------------------------------------------------------
    // Curve point read port and segment arithmetic
    // ---------------------------------------------------------------
    assign pt_half = r_idx[0] ? r_curve[r_idx[IDX_W-1:1]][63:32]
                              : r_curve[r_idx[IDX_W-1:1]][31:0];
    assign pt_t    = signed'(pt_half[PT_W-1:0]);
    assign pt_d    = pt_half[2*PT_W-1:PT_W];
    assign t_ext   = PT_W'(r_temp);

    assign n_pts    = (r_point_count > NUM_W'(MAX_POINTS)) ? NUM_W'(MAX_POINTS)
                                                           : r_point_count;
    assign last_idx = IDX_W'(n_pts - NUM_W'(1));

    assign span_w = (PT_W+1)'(pt_t) - (PT_W+1)'(r_prev_t);
    assign dist_w = (PT_W+1)'(t_ext) - (PT_W+1)'(r_prev_t);
    assign dd_w   = signed'({1'b0, pt_d}) - signed'({1'b0, r_prev_d});
    assign dd_neg = -dd_w;

    // The product's top half is already below the span, so only 16 quotient
    // bits remain to be found.
    assign prod       = r_dist * r_mag;
    assign trial      = {r_rem, r_quo[PT_W-1]};
    assign trial_ge   = trial >= {1'b0, r_span};
    assign trial_diff = trial - {1'b0, r_span};

    // ---------------------------------------------------------------
    // Final clamp
    // ---------------------------------------------------------------
    assign interp    = r_neg ? ({1'b0, r_lo} - {1'b0, r_quo})
                             : ({1'b0, r_lo} + {1'b0, r_quo});
    assign raw_w     = r_direct ? {1'b0, r_raw} : interp;
    assign floor_sat = (r_floor_duty > FULL_DUTY) ? FULL_DUTY : r_floor_duty;
    assign capped    = (raw_w > (PT_W+1)'(FULL_DUTY)) ? FULL_DUTY : raw_w[DUTY_W-1:0];
    assign duty      = (capped < floor_sat) ? floor_sat : capped;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_temp      = r_temp;
        n_idx       = r_idx;
        n_prev_t    = r_prev_t;
        n_prev_d    = r_prev_d;
        n_direct    = r_direct;
        n_raw       = r_raw;
        n_lo        = r_lo;
        n_span      = r_span;
        n_dist      = r_dist;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_duty  = r_out_duty;
        n_out_temp  = r_out_temp;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_temp  = blend_t;
                    n_idx   = '0;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                if (n_pts == '0) begin
                    // Empty curve: a zero raw duty leaves the floor after the clamp.
                    n_direct = 1'b1;
                    n_raw    = '0;
                    n_state  = S_FIN;
                end else if (t_ext <= pt_t) begin
                    n_direct = 1'b1;
                    n_raw    = pt_d;
                    n_state  = S_FIN;
                end else begin
                    n_prev_t = pt_t;
                    n_prev_d = pt_d;
                    n_idx    = last_idx;
                    n_state  = S_LAST;
                end
            end
            S_LAST: begin
                if (t_ext >= pt_t) begin
                    n_direct = 1'b1;
                    n_raw    = pt_d;
                    n_state  = S_FIN;
                end else begin
                    n_idx   = IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (t_ext <= pt_t) begin
                    if (span_w[PT_W] || (span_w == '0)) begin
                        // Flat or reversed segment takes the upper point's duty.
                        n_direct = 1'b1;
                        n_raw    = pt_d;
                        n_state  = S_FIN;
                    end else begin
                        n_direct = 1'b0;
                        n_lo     = r_prev_d;
                        n_span   = span_w[PT_W-1:0];
                        n_dist   = dist_w[PT_W-1:0];
                        n_neg    = dd_w[PT_W];
                        n_mag    = dd_w[PT_W] ? dd_neg[PT_W-1:0] : dd_w[PT_W-1:0];
                        n_state  = S_MUL;
                    end
                end else begin
                    n_prev_t = pt_t;
                    n_prev_d = pt_d;
                    n_idx    = r_idx + IDX_W'(1);
                end
            end
            S_MUL: begin
                n_rem   = prod[2*PT_W-1:PT_W];
                n_quo   = prod[PT_W-1:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = trial_ge ? trial_diff[PT_W-1:0] : trial[PT_W-1:0];
                n_quo = {r_quo[PT_W-2:0], trial_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_duty  = duty;
                    n_out_temp  = r_temp;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_temp     <= n_temp;
        r_idx      <= n_idx;
        r_prev_t   <= n_prev_t;
        r_prev_d   <= n_prev_d;
        r_direct   <= n_direct;
        r_raw      <= n_raw;
        r_lo       <= n_lo;
        r_span     <= n_span;
        r_dist     <= n_dist;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_duty <= n_out_duty;
        r_out_temp <= n_out_temp;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.fan_duty     = r_out_duty;
    assign o_out.blended_temp = r_out_temp;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_span))
        else $error("divider remainder not below the segment span");

    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= FULL_DUTY))
        else $error("fan duty above full scale");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_cnt == '0)) |-> ($past(r_state) == S_MUL))
        else $error("divider started without a product");

endmodule

`default_nettype wire
